### src/epc_pkg.sv
package epc_pkg;

  localparam int CMD_W      = 2;
  localparam int ELAPSED_W  = 16;
  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int MODE_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int RATIO_W    = 24;
  localparam int TICKS_W    = 16;
  localparam int LEFT_W     = 17;
  localparam int FRAC_W     = 16;
  localparam int WIN_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = RATIO_W + ELAPSED_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int WHOLE_W    = ACC_W - FRAC_W;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ARM   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_START = 2'd3;

  localparam logic [MODE_W-1:0] MODE_ERASE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ERASE       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE       = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESERVED    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_RATIO       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READY_IRQ_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_WRITE_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERASE_TICKS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_TICKS       = 3'd4;

  localparam logic [RATIO_W-1:0] RATIO_RESET       = 24'd65536;
  localparam logic [TICKS_W-1:0] ERASE_WRITE_RESET = 16'd3400;
  localparam logic [TICKS_W-1:0] ERASE_RESET       = 16'd1800;
  localparam logic [TICKS_W-1:0] WRITE_RESET       = 16'd1800;

  localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TICK_MUL,
    S_TICK_ACC,
    S_READ_WAIT,
    S_AND_WRITE,
    S_EMIT
  } epc_state_t;

endpackage

### src/epc_if.sv
interface epc_cmd_if import epc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [ELAPSED_W-1:0] elapsed;
  logic [ADDR_W-1:0]    address;
  logic [DATA_W-1:0]    write_data;
  logic [MODE_W-1:0]    mode;
  logic                 spm_busy;

  modport source (output valid, cmd, elapsed, address, write_data, mode, spm_busy,
                  input ready);
  modport sink (input valid, cmd, elapsed, address, write_data, mode, spm_busy,
                output ready);
endinterface

interface epc_result_if import epc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   read_data;
  logic                read_valid;
  logic [STATUS_W-1:0] start_status;
  logic                program_busy;
  logic                master_enabled;
  logic                irq_request;
  logic                device_busy;

  modport source (output valid, read_data, read_valid, start_status, program_busy,
                  master_enabled, irq_request, device_busy, input ready);
  modport sink (input valid, read_data, read_valid, start_status, program_busy,
                master_enabled, irq_request, device_busy, output ready);
endinterface

### src/eeprom_program_controller.sv
// Path from accept to result beat: arm, start and a busy or out-of-range read go via S_EMIT,
// a read from the store via S_READ_WAIT, a tick via S_TICK_MUL and S_TICK_ACC, and a tick
// that completes a write-only (AND) program via S_AND_WRITE too. One item at a time, set by
// the single-port byte store and the registered ratio multiply then accumulate/compare.
// Reset (synchronous): after rst the store is swept to 0xFF, one byte a cycle, with no item
// accepted until the sweep ends; config writes are taken throughout.
module eeprom_program_controller import epc_pkg::*; #(
  parameter int MEM_DEPTH     = 1024,
  parameter int WINDOW_CYCLES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  epc_cmd_if.sink               cmd_ch,
  epc_result_if.source          result_ch
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam logic [AW-1:0]     LAST_ADDR   = AW'(MEM_DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_LIMIT = (ADDR_W + 1)'(MEM_DEPTH);
  localparam logic [WIN_W-1:0]  WIN_LOAD    = WIN_W'(WINDOW_CYCLES);

  epc_state_t state, state_next;

  // configuration
  logic [RATIO_W-1:0] clock_ratio;
  logic               ready_irq_enable;
  logic [TICKS_W-1:0] erase_write_ticks;
  logic [TICKS_W-1:0] erase_ticks;
  logic [TICKS_W-1:0] write_ticks;

  // controller state
  logic [AW-1:0]      clr_addr;
  logic [FRAC_W-1:0]  clock_fraction;
  logic [LEFT_W-1:0]  ticks_left;
  logic               op_pending;
  logic [ADDR_W-1:0]  op_address;
  logic [DATA_W-1:0]  op_data;
  logic [MODE_W-1:0]  op_mode;
  logic [WIN_W-1:0]   window_count;
  logic               window_open;
  logic               window_fresh;

  // per-item working registers
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [PROD_W-1:0]    prod;
  logic [DATA_W-1:0]    res_read_data;
  logic                 res_read_valid;
  logic [STATUS_W-1:0]  res_status;

  // result beat register
  logic                out_valid;
  logic [DATA_W-1:0]   out_read_data;
  logic                out_read_valid;
  logic [STATUS_W-1:0] out_start_status;
  logic                out_program_busy;
  logic                out_master_enabled;
  logic                out_irq_request;
  logic                out_device_busy;

  // store port
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  logic               in_fire;
  logic               in_range;
  logic               op_in_range;
  logic               start_reject;
  logic [ACC_W-1:0]   acc;
  logic [WHOLE_W-1:0] whole;
  logic               finish;
  logic [WIN_W-1:0]   win_count_next;
  logic               emit_load;

  epc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign cmd_ch.ready = (state == S_IDLE);
  assign in_fire      = cmd_ch.valid && cmd_ch.ready;
  assign in_range     = {1'b0, cmd_ch.address} < DEPTH_LIMIT;
  assign op_in_range  = {1'b0, op_address} < DEPTH_LIMIT;
  assign start_reject = cmd_ch.spm_busy || !window_open || (cmd_ch.mode == MODE_RESERVED)
                        || op_pending;

  assign acc    = ACC_W'(prod) + ACC_W'(clock_fraction);
  assign whole  = acc[ACC_W-1:FRAC_W];
  assign finish = op_pending && (WHOLE_W'(ticks_left) <= whole);

  always_comb begin
    win_count_next = window_count;
    if (window_open && !window_fresh) begin
      if (elapsed_r >= ELAPSED_W'(window_count)) begin
        win_count_next = '0;
      end else begin
        win_count_next = window_count - elapsed_r[WIN_W-1:0];
      end
    end
  end

  assign emit_load = (state == S_EMIT) && (!out_valid || result_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_addr   = cmd_ch.address[AW-1:0];
    ram_wdata  = ERASED_BYTE;
    case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_ch.valid) begin
          case (cmd_ch.cmd)
            CMD_TICK: state_next = S_TICK_MUL;
            CMD_READ: state_next = (!op_pending && in_range) ? S_READ_WAIT : S_EMIT;
            default:  state_next = S_EMIT;
          endcase
        end
      end
      S_TICK_MUL: state_next = S_TICK_ACC;
      S_TICK_ACC: begin
        ram_addr   = op_address[AW-1:0];
        state_next = S_EMIT;
        if (finish && op_in_range) begin
          case (op_mode)
            MODE_ERASE_WRITE: begin
              ram_we    = 1'b1;
              ram_wdata = op_data;
            end
            MODE_ERASE: begin
              ram_we    = 1'b1;
              ram_wdata = ERASED_BYTE;
            end
            default: begin
              // write-only ANDs into the old byte: fetch it first
              state_next = S_AND_WRITE;
            end
          endcase
        end
      end
      S_READ_WAIT: state_next = S_EMIT;
      S_AND_WRITE: begin
        ram_we     = 1'b1;
        ram_addr   = op_address[AW-1:0];
        ram_wdata  = ram_rdata & op_data;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || result_ch.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr          <= '0;
      clock_fraction    <= '0;
      ticks_left        <= '0;
      op_pending        <= 1'b0;
      window_count      <= '0;
      window_open       <= 1'b0;
      window_fresh      <= 1'b0;
      clock_ratio       <= RATIO_RESET;
      ready_irq_enable  <= 1'b0;
      erase_write_ticks <= ERASE_WRITE_RESET;
      erase_ticks       <= ERASE_RESET;
      write_ticks       <= WRITE_RESET;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLOCK_RATIO:       clock_ratio       <= cfg_data[RATIO_W-1:0];
          REG_READY_IRQ_ENABLE:  ready_irq_enable  <= cfg_data[0];
          REG_ERASE_WRITE_TICKS: erase_write_ticks <= cfg_data[TICKS_W-1:0];
          REG_ERASE_TICKS:       erase_ticks       <= cfg_data[TICKS_W-1:0];
          REG_WRITE_TICKS:       write_ticks       <= cfg_data[TICKS_W-1:0];
          default: ;
        endcase
      end

      case (state)
        S_CLEAR: clr_addr <= clr_addr + 1'b1;
        S_IDLE: begin
          if (in_fire) begin
            case (cmd_ch.cmd)
              CMD_ARM: begin
                window_count <= WIN_LOAD;
                window_open  <= 1'b1;
                window_fresh <= 1'b1;
              end
              CMD_START: begin
                if (!start_reject) begin
                  op_pending <= 1'b1;
                  case (cmd_ch.mode)
                    MODE_ERASE_WRITE: ticks_left <= LEFT_W'(erase_write_ticks);
                    MODE_ERASE:       ticks_left <= LEFT_W'(erase_ticks);
                    default:          ticks_left <= LEFT_W'(write_ticks);
                  endcase
                end
              end
              default: ;
            endcase
          end
        end
        S_TICK_ACC: begin
          clock_fraction <= acc[FRAC_W-1:0];
          window_count   <= win_count_next;
          window_open    <= window_open && (win_count_next != '0);
          window_fresh   <= 1'b0;
          if (finish) begin
            op_pending <= 1'b0;
            ticks_left <= '0;
          end else if (op_pending) begin
            ticks_left <= ticks_left - whole[LEFT_W-1:0];
          end
        end
        default: ;
      endcase

      // hold the beat until taken, refill behind it
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          elapsed_r      <= cmd_ch.elapsed;
          res_read_data  <= '0;
          res_read_valid <= 1'b0;
          res_status     <= (cmd_ch.cmd != CMD_START) ? ST_NONE :
                            start_reject ? ST_REJECTED : ST_ACCEPTED;
          if (cmd_ch.cmd == CMD_START) begin
            if (!start_reject) begin
              op_address <= cmd_ch.address;
              op_data    <= cmd_ch.write_data;
              op_mode    <= cmd_ch.mode;
            end
          end
        end
      end
      S_TICK_MUL: prod <= PROD_W'(clock_ratio) * PROD_W'(elapsed_r);
      S_READ_WAIT: begin
        res_read_data  <= ram_rdata;
        res_read_valid <= 1'b1;
      end
      default: ;
    endcase

    if (emit_load) begin
      out_read_data      <= res_read_data;
      out_read_valid     <= res_read_valid;
      out_start_status   <= res_status;
      out_program_busy   <= op_pending;
      out_master_enabled <= window_open;
      out_irq_request    <= ready_irq_enable && !op_pending;
      out_device_busy    <= op_pending || ready_irq_enable || window_open;
    end
  end

  assign result_ch.valid          = out_valid;
  assign result_ch.read_data      = out_read_data;
  assign result_ch.read_valid     = out_read_valid;
  assign result_ch.start_status   = out_start_status;
  assign result_ch.program_busy   = out_program_busy;
  assign result_ch.master_enabled = out_master_enabled;
  assign result_ch.irq_request    = out_irq_request;
  assign result_ch.device_busy    = out_device_busy;

endmodule

### src/epc_ram.sv
module epc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### dv/eeprom_program_controller_tb.sv
module eeprom_program_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import epc_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int WINDOW_LEN  = 4;
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    logic [CMD_W-1:0]     cmd;
    logic [ELAPSED_W-1:0] elapsed;
    logic [ADDR_W-1:0]    address;
    logic [DATA_W-1:0]    write_data;
    logic [MODE_W-1:0]    mode;
    logic                 spm_busy;
  } eeprom_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic                read_valid;
    logic [STATUS_W-1:0] start_status;
    logic                program_busy;
    logic                master_enabled;
    logic                irq_request;
    logic                device_busy;
  } eeprom_status_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  epc_cmd_if    cmd_ch ();
  epc_result_if result_ch ();

  eeprom_program_controller #(
    .MEM_DEPTH     (STORE_DEPTH),
    .WINDOW_CYCLES (WINDOW_LEN)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_ch    (cmd_ch),
    .result_ch (result_ch)
  );

  // Shadow of the controller state and its registers
  bit [DATA_W-1:0]  shadow_cells [STORE_DEPTH];
  bit [FRAC_W-1:0]  clk_frac;
  bit [LEFT_W-1:0]  ticks_remaining;
  bit               op_active;
  bit [ADDR_W-1:0]  op_addr;
  bit [DATA_W-1:0]  op_byte;
  bit [MODE_W-1:0]  op_kind;
  bit [WIN_W-1:0]   window_left;
  bit               window_open;
  bit               window_fresh;
  bit [RATIO_W-1:0] ratio_q16;
  bit               irq_enable;
  bit [TICKS_W-1:0] erase_write_len;
  bit [TICKS_W-1:0] erase_only_len;
  bit [TICKS_W-1:0] write_only_len;

  eeprom_cmd_t    cmd_backlog [$];
  eeprom_status_t status_due [$];
  int unsigned    queued_cmds;
  int unsigned    mismatch_count;
  int unsigned    send_gap;
  int unsigned    recv_stall;
  int unsigned    quiet_cycles;
  bit             send_burst;
  bit             recv_burst;

  function automatic eeprom_status_t predict_status(input eeprom_cmd_t c);
    eeprom_status_t   r;
    bit [ACC_W-1:0]   acc;
    bit [ACC_W-1:0]   span;
    bit [WHOLE_W-1:0] whole;
    r = '0;
    r.start_status = ST_NONE;
    case (c.cmd)
      CMD_TICK: begin
        acc = ACC_W'(ratio_q16);
        span = ACC_W'(c.elapsed);
        acc = acc * span + ACC_W'(clk_frac);
        whole = acc[ACC_W-1:FRAC_W];
        clk_frac = acc[FRAC_W-1:0];
        if (window_open && !window_fresh) begin
          if (c.elapsed >= window_left) window_left = '0;
          else window_left = window_left - c.elapsed[WIN_W-1:0];
        end
        if (window_left == '0) window_open = 1'b0;
        window_fresh = 1'b0;
        if (op_active) begin
          if (whole >= ticks_remaining) begin
            // out of range target completes without touching the store
            if (op_addr < STORE_DEPTH) begin
              case (op_kind)
                MODE_ERASE_WRITE: shadow_cells[op_addr[STORE_AW-1:0]] = op_byte;
                MODE_ERASE:       shadow_cells[op_addr[STORE_AW-1:0]] = ERASED_BYTE;
                MODE_WRITE:       shadow_cells[op_addr[STORE_AW-1:0]] =
                                    shadow_cells[op_addr[STORE_AW-1:0]] & op_byte;
                default: ;
              endcase
            end
            op_active = 1'b0;
            ticks_remaining = '0;
          end else begin
            ticks_remaining = ticks_remaining - whole[LEFT_W-1:0];
          end
        end
      end
      CMD_ARM: begin
        window_left = WIN_W'(WINDOW_LEN);
        window_open = 1'b1;
        window_fresh = 1'b1;
      end
      CMD_READ: begin
        if (!op_active && c.address < STORE_DEPTH) begin
          r.read_data = shadow_cells[c.address[STORE_AW-1:0]];
          r.read_valid = 1'b1;
        end
      end
      default: begin
        if (c.spm_busy || !window_open || c.mode == MODE_RESERVED || op_active) begin
          r.start_status = ST_REJECTED;
        end else begin
          r.start_status = ST_ACCEPTED;
          op_active = 1'b1;
          op_addr = c.address;
          op_byte = c.write_data;
          op_kind = c.mode;
          if (c.mode == MODE_ERASE_WRITE) ticks_remaining = LEFT_W'(erase_write_len);
          else if (c.mode == MODE_ERASE) ticks_remaining = LEFT_W'(erase_only_len);
          else ticks_remaining = LEFT_W'(write_only_len);
        end
      end
    endcase
    r.program_busy = op_active;
    r.master_enabled = window_open;
    r.irq_request = irq_enable && !op_active;
    r.device_busy = op_active || irq_enable || window_open;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [ELAPSED_W-1:0] el,
                           input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d,
                           input logic [MODE_W-1:0] m, input logic s);
    eeprom_cmd_t item;
    item.cmd = c;
    item.elapsed = el;
    item.address = a;
    item.write_data = d;
    item.mode = m;
    item.spm_busy = s;
    cmd_backlog.push_back(item);
    queued_cmds++;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    case ($urandom_range(0, 7))
      0, 1, 2, 3, 4: return ADDR_W'($urandom_range(0, 15));
      5:             return ADDR_W'($urandom_range(0, STORE_DEPTH - 1));
      6:             return ADDR_W'($urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 1));
      default:       return ADDR_W'($urandom());
    endcase
  endfunction

  function automatic logic [ELAPSED_W-1:0] pick_elapsed();
    case ($urandom_range(0, 3))
      0:       return ELAPSED_W'($urandom_range(0, 7));
      1:       return ELAPSED_W'($urandom_range(0, 255));
      2:       return ELAPSED_W'($urandom_range(0, 4095));
      default: return ELAPSED_W'($urandom());
    endcase
  endfunction

  // Mostly arm/start/tick/read sequences so programs actually land in the store
  task automatic queue_traffic(input int unsigned n);
    int unsigned         target;
    logic [ADDR_W-1:0]   addr;
    logic [MODE_W-1:0]   kind;
    target = queued_cmds + n;
    while (queued_cmds < target) begin
      if ($urandom_range(0, 3) != 0) begin
        addr = pick_address();
        if ($urandom_range(0, 9) == 0) kind = MODE_RESERVED;
        else if ($urandom_range(0, 2) == 0) kind = MODE_ERASE_WRITE;
        else if ($urandom_range(0, 1) == 0) kind = MODE_ERASE;
        else kind = MODE_WRITE;
        queue_cmd(CMD_ARM, ELAPSED_W'($urandom()), ADDR_W'($urandom()),
                  DATA_W'($urandom()), MODE_W'($urandom()), 1'($urandom()));
        repeat ($urandom_range(0, 2))
          queue_cmd(CMD_TICK, ELAPSED_W'($urandom_range(0, 5)), ADDR_W'($urandom()),
                    DATA_W'($urandom()), MODE_W'($urandom()), 1'($urandom()));
        queue_cmd(CMD_START, ELAPSED_W'($urandom()), addr, DATA_W'($urandom()), kind,
                  $urandom_range(0, 15) == 0);
        repeat ($urandom_range(1, 4))
          queue_cmd(CMD_TICK, pick_elapsed(), ADDR_W'($urandom()), DATA_W'($urandom()),
                    MODE_W'($urandom()), 1'($urandom()));
        queue_cmd(CMD_READ, ELAPSED_W'($urandom()), addr, DATA_W'($urandom()),
                  MODE_W'($urandom()), 1'($urandom()));
      end else begin
        repeat ($urandom_range(1, 3))
          queue_cmd(CMD_W'($urandom()), pick_elapsed(), pick_address(), DATA_W'($urandom()),
                    MODE_W'($urandom()), 1'($urandom()));
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CLOCK_RATIO:       ratio_q16 = value[RATIO_W-1:0];
      REG_READY_IRQ_ENABLE:  irq_enable = value[0];
      REG_ERASE_WRITE_TICKS: erase_write_len = value[TICKS_W-1:0];
      REG_ERASE_TICKS:       erase_only_len = value[TICKS_W-1:0];
      REG_WRITE_TICKS:       write_only_len = value[TICKS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [RATIO_W-1:0] ratio, input logic irq,
                             input logic [TICKS_W-1:0] ew, input logic [TICKS_W-1:0] e,
                             input logic [TICKS_W-1:0] w);
    write_reg(REG_CLOCK_RATIO, CFG_DATA_W'(ratio));
    write_reg(REG_READY_IRQ_ENABLE, CFG_DATA_W'(irq));
    write_reg(REG_ERASE_WRITE_TICKS, CFG_DATA_W'(ew));
    write_reg(REG_ERASE_TICKS, CFG_DATA_W'(e));
    write_reg(REG_WRITE_TICKS, CFG_DATA_W'(w));
  endtask

  // Hold until every queued command is accepted and answered, then let the pipe empty
  task automatic settle();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || status_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Command driver: predict on every accepted beat, then present the next one
  always @(posedge clk) begin
    eeprom_cmd_t seen;
    eeprom_cmd_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        seen.cmd = cmd_ch.cmd;
        seen.elapsed = cmd_ch.elapsed;
        seen.address = cmd_ch.address;
        seen.write_data = cmd_ch.write_data;
        seen.mode = cmd_ch.mode;
        seen.spm_busy = cmd_ch.spm_busy;
        status_due.push_back(predict_status(seen));
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          cmd_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          nxt = cmd_backlog.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.cmd <= nxt.cmd;
          cmd_ch.elapsed <= nxt.elapsed;
          cmd_ch.address <= nxt.address;
          cmd_ch.write_data <= nxt.write_data;
          cmd_ch.mode <= nxt.mode;
          cmd_ch.spm_busy <= nxt.spm_busy;
          if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 7);
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure
  always @(posedge clk) begin
    eeprom_status_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (status_due.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatch_count++;
        end else begin
          want = status_due.pop_front();
          check_field("read_data", 32'(want.read_data), 32'(result_ch.read_data));
          check_field("read_valid", 32'(want.read_valid), 32'(result_ch.read_valid));
          check_field("start_status", 32'(want.start_status), 32'(result_ch.start_status));
          check_field("program_busy", 32'(want.program_busy), 32'(result_ch.program_busy));
          check_field("master_enabled", 32'(want.master_enabled),
                      32'(result_ch.master_enabled));
          check_field("irq_request", 32'(want.irq_request), 32'(result_ch.irq_request));
          check_field("device_busy", 32'(want.device_busy), 32'(result_ch.device_busy));
        end
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 7);
      end
      if (recv_stall != 0) begin
        recv_stall--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (result_ch.valid && result_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL eeprom_program_controller");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_TICK;
    cmd_ch.elapsed = '0;
    cmd_ch.address = '0;
    cmd_ch.write_data = '0;
    cmd_ch.mode = MODE_ERASE_WRITE;
    cmd_ch.spm_busy = 1'b0;
    result_ch.ready = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) shadow_cells[i] = ERASED_BYTE;
    clk_frac = '0;
    ticks_remaining = '0;
    op_active = 1'b0;
    op_addr = '0;
    op_byte = '0;
    op_kind = MODE_ERASE_WRITE;
    window_left = '0;
    window_open = 1'b0;
    window_fresh = 1'b0;
    ratio_q16 = RATIO_RESET;
    irq_enable = 1'b0;
    erase_write_len = ERASE_WRITE_RESET;
    erase_only_len = ERASE_RESET;
    write_only_len = WRITE_RESET;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: range edges, rejections, window expiry, every program mode
    queue_cmd(CMD_READ, 16'd0, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_READ, 16'd0, 16'(STORE_DEPTH - 1), 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_READ, 16'd0, 16'(STORE_DEPTH), 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_START, 16'd0, 16'd5, 8'hA5, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_ARM, 16'd0, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_START, 16'd0, 16'd5, 8'hA5, MODE_ERASE_WRITE, 1'b1);
    queue_cmd(CMD_START, 16'd0, 16'd5, 8'hA5, MODE_RESERVED, 1'b0);
    queue_cmd(CMD_START, 16'd0, 16'd5, 8'hA5, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_START, 16'd0, 16'd6, 8'h11, MODE_ERASE, 1'b0);
    queue_cmd(CMD_READ, 16'd0, 16'd5, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_TICK, 16'hFFFF, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_READ, 16'd0, 16'd5, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_TICK, 16'd3, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_TICK, 16'd1, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_START, 16'd0, 16'd5, 8'hFF, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_ARM, 16'd0, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_TICK, 16'd0, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_START, 16'd0, 16'd5, 8'h3C, MODE_WRITE, 1'b0);
    queue_cmd(CMD_TICK, 16'hFFFF, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_READ, 16'd0, 16'd5, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_ARM, 16'd0, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_START, 16'd0, 16'd5, 8'h00, MODE_ERASE, 1'b0);
    queue_cmd(CMD_TICK, 16'hFFFF, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_READ, 16'd0, 16'd5, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_ARM, 16'd0, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_START, 16'd0, 16'hFFFF, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_TICK, 16'hFFFF, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_traffic(250);
    settle();

    load_config(24'hFFFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_traffic(250);
    settle();

    // No clock advance: programs stay pending until a later setting
    load_config(24'd0, 1'b0, 16'd1, 16'd1, 16'd1);
    queue_traffic(100);
    settle();

    load_config(24'd1, 1'b1, 16'd1, 16'd2, 16'd3);
    queue_traffic(150);
    settle();

    // Zero-length programs complete on the next tick even with no elapsed time
    load_config(RATIO_RESET, 1'b0, 16'd0, 16'd0, 16'd0);
    queue_cmd(CMD_TICK, 16'd0, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_ARM, 16'd0, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_START, 16'd0, 16'd7, 8'h0F, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_TICK, 16'd0, 16'd0, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_cmd(CMD_READ, 16'd0, 16'd7, 8'h00, MODE_ERASE_WRITE, 1'b0);
    queue_traffic(200);
    settle();

    repeat (4) begin
      load_config(RATIO_W'($urandom_range(24'h100, 24'h40000)), 1'($urandom_range(0, 1)),
                  TICKS_W'($urandom_range(1, 4000)), TICKS_W'($urandom_range(1, 4000)),
                  TICKS_W'($urandom_range(1, 4000)));
      queue_traffic(250);
      settle();
    end

    load_config(24'h8000, 1'b1, 16'hFFFF, 16'd1, 16'd40);
    queue_traffic(200);
    settle();

    if (mismatch_count == 0 && status_due.size() == 0) begin
      $display("PASS eeprom_program_controller");
    end else begin
      $display("FAIL eeprom_program_controller");
    end
    $finish;
  end

endmodule

### eeprom_program_controller.f
src/epc_pkg.sv
src/epc_if.sv
src/epc_ram.sv
src/eeprom_program_controller.sv
dv/eeprom_program_controller_tb.sv
